@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AFFQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define AFFQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/affq_pkg.sv @@
// Types and constants of the affine matrix to TRS quaternion block.
`timescale 1ns / 1ps

package affq_pkg;

  // Register stages of one square root or one divide unit
  localparam int unsigned UNIT_LAT = 32;
  // Radicand and dividend width inside the digit units
  localparam int unsigned RAD_W = 64;

  // 1.0 in Q2.30
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } unit_mode_e;

  // Which quaternion component comes from the root directly
  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } branch_e;

  typedef struct packed {
    logic signed [31:0] basis_x_x;
    logic signed [31:0] basis_x_y;
    logic signed [31:0] basis_x_z;
    logic signed [31:0] basis_y_x;
    logic signed [31:0] basis_y_y;
    logic signed [31:0] basis_y_z;
    logic signed [31:0] basis_z_x;
    logic signed [31:0] basis_z_y;
    logic signed [31:0] basis_z_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } trs_in_t;

  typedef struct packed {
    logic signed [31:0] translation_x;
    logic signed [31:0] translation_y;
    logic signed [31:0] translation_z;
    logic [30:0]        scale_x;
    logic [30:0]        scale_y;
    logic [30:0]        scale_z;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic               rotation_valid;
  } trs_out_t;

endpackage

@@ sv/affine_matrix_to_trs_quaternion_top.sv @@
// Affine 3x4 matrix to translation, scale and rotation quaternion, fully pipelined.
//
//   channel | valid       | stall        | data
//   --------+-------------+--------------+-----------------------
//   in      | in_valid_i  | in_stall_o   | in_data_i  (trs_in_t)
//   out     | out_valid_o | out_stall_i  | out_data_o (trs_out_t)
//
// Pipeline: three setup stages, column root (32), element divide (32),
// three trace/branch stages, quaternion root (32), component divide (32), output.
// One beat enters per cycle unless the output is stalled; the bit-serial root and divide units set the depth.
// Reset clears only the valid bits of the stages.
// A stalled output freezes every stage at once, so in_stall_o follows out_stall_i
// while the output holds a beat.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module affine_matrix_to_trs_quaternion_top import affq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  trs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output trs_out_t out_data_o
);

  localparam int unsigned NSTG = 3 + 4 * UNIT_LAT + 3 + 1;

  typedef struct packed {
    logic [8:0][31:0] mag;
    logic [8:0]       neg;
    logic [2:0][31:0] off;
  } sb1_t;

  typedef struct packed {
    logic [2:0][31:0] off;
    logic [2:0][30:0] scale;
    logic             ok;
  } sb3_t;

  typedef struct packed {
    logic [8:0] neg;
    sb3_t       com;
  } sb2_t;

  typedef struct packed {
    branch_e          br;
    logic [2:0][31:0] nmag;
    logic [2:0]       nneg;
    sb3_t             com;
  } sb4_t;

  typedef struct packed {
    branch_e     br;
    logic [2:0]  nneg;
    logic [31:0] root;
    sb3_t        com;
  } sb5_t;

  logic            en;
  logic [NSTG-1:0] vld_q;

  // Global advance: everything moves unless a held output beat is stalled
  assign en          = !(vld_q[NSTG-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // Stage A: magnitudes and signs
  logic signed [31:0] m [9];
  sb1_t a_q, b_q, c_q;
  logic [63:0] sq_q [9];
  logic [63:0] sum_q [3];

  assign m[0] = in_data_i.basis_x_x;
  assign m[1] = in_data_i.basis_x_y;
  assign m[2] = in_data_i.basis_x_z;
  assign m[3] = in_data_i.basis_y_x;
  assign m[4] = in_data_i.basis_y_y;
  assign m[5] = in_data_i.basis_y_z;
  assign m[6] = in_data_i.basis_z_x;
  assign m[7] = in_data_i.basis_z_y;
  assign m[8] = in_data_i.basis_z_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        a_q.neg[e] <= m[e][31];
        a_q.mag[e] <= m[e][31] ? 32'(-m[e]) : 32'(m[e]);
      end
      a_q.off[0] <= in_data_i.offset_x;
      a_q.off[1] <= in_data_i.offset_y;
      a_q.off[2] <= in_data_i.offset_z;
    end
  end

  // Stage B: squares; stage C: column sums
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_q <= a_q;
      for (int e = 0; e < 9; e++) begin
        sq_q[e] <= 64'(a_q.mag[e]) * 64'(a_q.mag[e]);
      end
      c_q <= b_q;
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= sq_q[3*c] + sq_q[3*c+1] + sq_q[3*c+2];
      end
    end
  end

  // Column lengths
  logic [31:0] len [3];
  sb1_t        d1_q [UNIT_LAT];

  for (genvar c = 0; c < 3; c++) begin : g_len
    affq_digit_pipe #(.MODE(MODE_SQRT)) u_len (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (sum_q[c]),
      .b_i   ('0),
      .q_o   (len[c])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= c_q;
      for (int i = 1; i < UNIT_LAT; i++) d1_q[i] <= d1_q[i-1];
    end
  end

  // Normalize elements by their column length
  sb1_t        d1_o;
  sb2_t        d2_in;
  sb2_t        d2_q [UNIT_LAT];
  logic [31:0] rmag [9];

  assign d1_o = d1_q[UNIT_LAT-1];

  always_comb begin
    d2_in.neg     = d1_o.neg;
    d2_in.com.off = d1_o.off;
    d2_in.com.ok  = (len[0] != '0) && (len[1] != '0) && (len[2] != '0);
    for (int c = 0; c < 3; c++) begin
      d2_in.com.scale[c] = len[c][31] ? 31'h7FFF_FFFF : len[c][30:0];
    end
  end

  for (genvar e = 0; e < 9; e++) begin : g_norm
    affq_digit_pipe #(.MODE(MODE_DIV)) u_norm (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({2'b00, d1_o.mag[e], 30'd0}),
      .b_i   ({1'b0, len[e/3]}),
      .q_o   (rmag[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q[0] <= d2_in;
      for (int i = 1; i < UNIT_LAT; i++) d2_q[i] <= d2_q[i-1];
    end
  end

  // Stage R: signed rotation elements
  logic signed [31:0] r_q [9];
  sb3_t r_sb_q, t1_sb_q, t2_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        r_q[e] <= d2_q[UNIT_LAT-1].neg[e] ? -$signed(rmag[e]) : $signed(rmag[e]);
      end
      r_sb_q <= d2_q[UNIT_LAT-1].com;
    end
  end

  // Stage T1: trace, diagonal compares, off-diagonal sums and differences
  logic signed [33:0] trace_q;
  logic               c01_q, c02_q, c12_q;
  logic signed [31:0] dg_q [3];
  logic signed [32:0] dd_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      trace_q <= 34'(r_q[0]) + 34'(r_q[4]) + 34'(r_q[8]);
      c01_q   <= r_q[0] > r_q[4];
      c02_q   <= r_q[0] > r_q[8];
      c12_q   <= r_q[4] > r_q[8];
      dg_q[0] <= r_q[0];
      dg_q[1] <= r_q[4];
      dg_q[2] <= r_q[8];
      dd_q[0] <= 33'(r_q[5]) - 33'(r_q[7]);  // r21 - r12
      dd_q[1] <= 33'(r_q[6]) - 33'(r_q[2]);  // r02 - r20
      dd_q[2] <= 33'(r_q[1]) - 33'(r_q[3]);  // r10 - r01
      dd_q[3] <= 33'(r_q[3]) + 33'(r_q[1]);  // r01 + r10
      dd_q[4] <= 33'(r_q[6]) + 33'(r_q[2]);  // r02 + r20
      dd_q[5] <= 33'(r_q[7]) + 33'(r_q[5]);  // r12 + r21
      t1_sb_q <= r_sb_q;
    end
  end

  // Stage T2: branch choice, root argument and divider numerators
  branch_e            br_d, br_q;
  logic signed [35:0] t_d, t_q;
  logic signed [32:0] n_d [3];
  logic [31:0]        nmag_q [3];
  logic [2:0]         nneg_q;

  always_comb begin
    if (trace_q > 0) begin
      br_d = BR_W;
      t_d  = 36'(Q30_ONE) + 36'(trace_q);
      n_d[0] = dd_q[0];
      n_d[1] = dd_q[1];
      n_d[2] = dd_q[2];
    end else if (c01_q && c02_q) begin
      br_d = BR_X;
      t_d  = 36'(Q30_ONE) + (36'(dg_q[0]) <<< 1) - 36'(trace_q);
      n_d[0] = dd_q[0];
      n_d[1] = dd_q[3];
      n_d[2] = dd_q[4];
    end else if (c12_q) begin
      br_d = BR_Y;
      t_d  = 36'(Q30_ONE) + (36'(dg_q[1]) <<< 1) - 36'(trace_q);
      n_d[0] = dd_q[1];
      n_d[1] = dd_q[3];
      n_d[2] = dd_q[5];
    end else begin
      br_d = BR_Z;
      t_d  = 36'(Q30_ONE) + (36'(dg_q[2]) <<< 1) - 36'(trace_q);
      n_d[0] = dd_q[2];
      n_d[1] = dd_q[4];
      n_d[2] = dd_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q <= br_d;
      t_q  <= t_d;
      for (int k = 0; k < 3; k++) begin
        nneg_q[k] <= n_d[k][32];
        nmag_q[k] <= n_d[k][32] ? 32'(-n_d[k]) : 32'(n_d[k]);
      end
      t2_sb_q <= t1_sb_q;
    end
  end

  // Quaternion root
  logic [RAD_W-1:0] root_arg;
  logic [31:0]      root;
  sb4_t             d4_q [UNIT_LAT];
  sb4_t             d4_o;

  assign root_arg = (t_q > 0) ? ({28'd0, t_q} << 30) : '0;

  affq_digit_pipe #(.MODE(MODE_SQRT)) u_root (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (root_arg),
    .b_i   ('0),
    .q_o   (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q[0].br  <= br_q;
      d4_q[0].com <= t2_sb_q;
      for (int k = 0; k < 3; k++) begin
        d4_q[0].nmag[k] <= nmag_q[k];
        d4_q[0].nneg[k] <= nneg_q[k];
      end
      for (int i = 1; i < UNIT_LAT; i++) d4_q[i] <= d4_q[i-1];
    end
  end

  assign d4_o = d4_q[UNIT_LAT-1];

  // Off-diagonal components divided by twice the root
  logic [31:0] qmag [3];
  sb5_t        d5_q [UNIT_LAT];
  sb5_t        d5_o;

  for (genvar k = 0; k < 3; k++) begin : g_comp
    affq_digit_pipe #(.MODE(MODE_DIV)) u_comp (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   ({2'b00, d4_o.nmag[k], 30'd0}),
      .b_i   ({root, 1'b0}),
      .q_o   (qmag[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q[0].br   <= d4_o.br;
      d5_q[0].nneg <= d4_o.nneg;
      d5_q[0].root <= root;
      d5_q[0].com  <= d4_o.com;
      for (int i = 1; i < UNIT_LAT; i++) d5_q[i] <= d5_q[i-1];
    end
  end

  assign d5_o = d5_q[UNIT_LAT-1];

  // Output stage: signs, component placement, identity when invalid
  logic signed [31:0] comp [3];
  logic signed [31:0] diag;
  trs_out_t           out_d, out_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp[k] = d5_o.nneg[k] ? -$signed(qmag[k]) : $signed(qmag[k]);
    end
    // Half the root, capped at one for a skewed basis
    diag = (d5_o.root[31:1] > 31'h4000_0000) ? Q30_ONE :
           $signed({1'b0, d5_o.root[31:1]});

    out_d.translation_x  = d5_o.com.off[0];
    out_d.translation_y  = d5_o.com.off[1];
    out_d.translation_z  = d5_o.com.off[2];
    out_d.scale_x        = d5_o.com.scale[0];
    out_d.scale_y        = d5_o.com.scale[1];
    out_d.scale_z        = d5_o.com.scale[2];
    out_d.rotation_valid = d5_o.com.ok;

    case (d5_o.br)
      BR_W: begin
        out_d.quat_w = diag;
        out_d.quat_x = comp[0];
        out_d.quat_y = comp[1];
        out_d.quat_z = comp[2];
      end
      BR_X: begin
        out_d.quat_w = comp[0];
        out_d.quat_x = diag;
        out_d.quat_y = comp[1];
        out_d.quat_z = comp[2];
      end
      BR_Y: begin
        out_d.quat_w = comp[0];
        out_d.quat_x = comp[1];
        out_d.quat_y = diag;
        out_d.quat_z = comp[2];
      end
      default: begin
        out_d.quat_w = comp[0];
        out_d.quat_x = comp[1];
        out_d.quat_y = comp[2];
        out_d.quat_z = diag;
      end
    endcase

    if (!d5_o.com.ok) begin
      out_d.quat_w = Q30_ONE;
      out_d.quat_x = '0;
      out_d.quat_y = '0;
      out_d.quat_z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // Checks
  logic quat_in_range;
  logic quat_ident;
  logic scales_nz;

  assign quat_in_range = (out_q.quat_x <= Q30_ONE) && (out_q.quat_x >= -Q30_ONE) &&
                         (out_q.quat_y <= Q30_ONE) && (out_q.quat_y >= -Q30_ONE) &&
                         (out_q.quat_z <= Q30_ONE) && (out_q.quat_z >= -Q30_ONE) &&
                         (out_q.quat_w <= Q30_ONE) && (out_q.quat_w >= -Q30_ONE);
  assign quat_ident    = (out_q.quat_w == Q30_ONE) && (out_q.quat_x == '0) &&
                         (out_q.quat_y == '0) && (out_q.quat_z == '0);
  assign scales_nz     = (out_q.scale_x != '0) && (out_q.scale_y != '0) &&
                         (out_q.scale_z != '0);

  `AFFQ_ASSERT_IMP(a_quat_range, clk_i, rst_ni, out_valid_o, quat_in_range)
  `AFFQ_ASSERT_IMP(a_invalid_ident, clk_i, rst_ni, out_valid_o && !out_q.rotation_valid, quat_ident)
  `AFFQ_ASSERT_IMP(a_valid_scales, clk_i, rst_ni, out_valid_o && out_q.rotation_valid, scales_nz)
  `AFFQ_ASSERT_NXT(a_entry, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0])

endmodule

@@ sv/affq_digit_pipe.sv @@
// Pipelined one-bit-per-stage integer square root or Q30 fractional divider.
`timescale 1ns / 1ps

module affq_digit_pipe import affq_pkg::*; #(
  parameter unit_mode_e MODE = MODE_SQRT
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RAD_W-1:0] a_i,
  input  logic [32:0]      b_i,
  output logic [31:0]      q_o
);

  if (MODE == MODE_SQRT) begin : g_sqrt
    // floor(sqrt(a)), one result bit per stage
    logic [RAD_W-1:0] rem_q [UNIT_LAT];
    logic [RAD_W-1:0] res_q [UNIT_LAT];
    logic [RAD_W-1:0] rem_in [UNIT_LAT];
    logic [RAD_W-1:0] res_in [UNIT_LAT];
    logic [RAD_W-1:0] rem_d [UNIT_LAT];
    logic [RAD_W-1:0] res_d [UNIT_LAT];

    always_comb begin
      logic [RAD_W-1:0] bitv;
      logic [RAD_W-1:0] trial;
      rem_in[0] = a_i;
      res_in[0] = '0;
      for (int s = 1; s < UNIT_LAT; s++) begin
        rem_in[s] = rem_q[s-1];
        res_in[s] = res_q[s-1];
      end
      for (int s = 0; s < UNIT_LAT; s++) begin
        bitv  = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2 - 2 * s);
        trial = res_in[s] + bitv;
        if (rem_in[s] >= trial) begin
          rem_d[s] = rem_in[s] - trial;
          res_d[s] = (res_in[s] >> 1) + bitv;
        end else begin
          rem_d[s] = rem_in[s];
          res_d[s] = res_in[s] >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int s = 0; s < UNIT_LAT; s++) begin
          rem_q[s] <= rem_d[s];
          res_q[s] <= res_d[s];
        end
      end
    end

    assign q_o = res_q[UNIT_LAT-1][31:0];

  end else begin : g_div
    // trunc(a / b) with a = num * 2^30, clamped to 2^30, zero divisor gives 0
    logic [RAD_W-1:0] rem_q [UNIT_LAT];
    logic [32:0]      den_q [UNIT_LAT];
    logic [30:0]      quo_q [UNIT_LAT];
    logic [UNIT_LAT-1:0] ovf_q;
    logic [UNIT_LAT-1:0] zero_q;
    logic [RAD_W-1:0] rem_d [UNIT_LAT];
    logic [30:0]      quo_d [UNIT_LAT];

    always_comb begin
      logic [RAD_W-1:0] trial;
      rem_d[0] = a_i;
      quo_d[0] = '0;
      for (int s = 1; s < UNIT_LAT; s++) begin
        trial    = {{(RAD_W-33){1'b0}}, den_q[s-1]} << (UNIT_LAT - 1 - s);
        rem_d[s] = rem_q[s-1];
        quo_d[s] = quo_q[s-1];
        if (rem_q[s-1] >= trial) begin
          rem_d[s] = rem_q[s-1] - trial;
          quo_d[s][UNIT_LAT-1-s] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[0]  <= b_i;
        ovf_q[0]  <= (a_i[RAD_W-1:31] >= b_i);
        zero_q[0] <= (b_i == '0);
        for (int s = 0; s < UNIT_LAT; s++) begin
          rem_q[s] <= rem_d[s];
          quo_q[s] <= quo_d[s];
        end
        for (int s = 1; s < UNIT_LAT; s++) begin
          den_q[s]  <= den_q[s-1];
          ovf_q[s]  <= ovf_q[s-1];
          zero_q[s] <= zero_q[s-1];
        end
      end
    end

    // Saturate at one; a zero divisor gives zero
    always_comb begin
      if (zero_q[UNIT_LAT-1]) begin
        q_o = '0;
      end else if (ovf_q[UNIT_LAT-1] || ({1'b0, quo_q[UNIT_LAT-1]} > Q30_ONE)) begin
        q_o = Q30_ONE;
      end else begin
        q_o = {1'b0, quo_q[UNIT_LAT-1]};
      end
    end
  end

endmodule
